// ----- sv/i2c_master_byte_engine_macros.svh -----
// Assertion macros for the I2C master byte engine.
// Used by the top level; expects signals clk and rst in scope.
`ifndef I2C_MASTER_BYTE_ENGINE_MACROS_SVH
`define I2C_MASTER_BYTE_ENGINE_MACROS_SVH
`ifndef SYNTH
`define MBE_CHECK_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define MBE_CHECK_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define MBE_CHECK_SAME(lbl, ante, cons, msg)
`define MBE_CHECK_NEXT(lbl, ante, cons, msg)
`endif
`endif

// ----- sv/i2c_mbe_pkg.sv -----
// Shared types and constants for the I2C master byte engine.
// No dependencies.
package i2c_mbe_pkg;

  typedef enum logic [4:0] {
    PH_IDLE = 5'd0,
    PH_ST_A = 5'd1,
    PH_ST_B = 5'd2,
    PH_SP_A = 5'd3,
    PH_SP_B = 5'd4,
    PH_WB_D = 5'd5,
    PH_WB_H = 5'd6,
    PH_WB_L = 5'd7,
    PH_RB_H = 5'd8,
    PH_RB_L = 5'd9,
    PH_SA_D = 5'd10,
    PH_SA_H = 5'd11,
    PH_SA_L = 5'd12,
    PH_RA_D = 5'd13,
    PH_RA_H = 5'd14,
    PH_RA_W = 5'd15,
    PH_RA_L = 5'd16
  } phase_t;

  localparam logic [3:0] REQ_TICK  = 4'd0;
  localparam logic [3:0] REQ_START = 4'd1;
  localparam logic [3:0] REQ_STOP  = 4'd2;
  localparam logic [3:0] REQ_WRITE = 4'd3;
  localparam logic [3:0] REQ_READ  = 4'd4;
  localparam logic [3:0] REQ_SACK  = 4'd5;
  localparam logic [3:0] REQ_RACK  = 4'd6;
  localparam logic [3:0] REQ_CMD   = 4'd7;
  localparam logic [3:0] REQ_DATA  = 4'd8;

  localparam logic [2:0] CFG_SLOT_TICKS  = 3'd0;
  localparam logic [2:0] CFG_ACK_TIMEOUT = 3'd1;
  localparam logic [2:0] CFG_SLAVE_ADDR  = 3'd2;
  localparam logic [2:0] CFG_CMD_PREFIX  = 3'd3;
  localparam logic [2:0] CFG_DATA_PREFIX = 3'd4;

  localparam logic [15:0] SLOT_TICKS_RST  = 16'd1;
  localparam logic [15:0] ACK_TIMEOUT_RST = 16'd1000;
  localparam logic [7:0]  SLAVE_ADDR_RST  = 8'h78;
  localparam logic [7:0]  CMD_PREFIX_RST  = 8'h00;
  localparam logic [7:0]  DATA_PREFIX_RST = 8'h40;

  localparam logic [3:0] BITS_PER_BYTE = 4'd8;

  typedef struct packed {
    logic [15:0] slot_ticks;
    logic [15:0] ack_timeout;
    logic [7:0]  slave_address_byte;
    logic [7:0]  command_prefix;
    logic [7:0]  data_prefix;
  } cfg_t;

  typedef struct packed {
    logic [3:0] req_type;
    logic [7:0] payload;
    logic       ack_level;
    logic       sda_in;
  } item_t;

  typedef struct packed {
    logic       scl_level;
    logic       sda_level;
    logic       busy_res;
    logic       done_res;
    logic [7:0] rx_byte;
    logic       nack_seen;
  } res_t;

  typedef struct packed {
    phase_t phase;
  } status_t;

endpackage

// ----- sv/i2c_mbe_cfg.sv -----
// Configuration register file for the I2C master byte engine.
// Depends on i2c_mbe_pkg.
module i2c_mbe_cfg (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [2:0]        cfg_index,
  input  logic [15:0]       cfg_data,
  output i2c_mbe_pkg::cfg_t cfg
);

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.slot_ticks         <= i2c_mbe_pkg::SLOT_TICKS_RST;
      cfg.ack_timeout        <= i2c_mbe_pkg::ACK_TIMEOUT_RST;
      cfg.slave_address_byte <= i2c_mbe_pkg::SLAVE_ADDR_RST;
      cfg.command_prefix     <= i2c_mbe_pkg::CMD_PREFIX_RST;
      cfg.data_prefix        <= i2c_mbe_pkg::DATA_PREFIX_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        i2c_mbe_pkg::CFG_SLOT_TICKS:  cfg.slot_ticks         <= cfg_data;
        i2c_mbe_pkg::CFG_ACK_TIMEOUT: cfg.ack_timeout        <= cfg_data;
        i2c_mbe_pkg::CFG_SLAVE_ADDR:  cfg.slave_address_byte <= cfg_data[7:0];
        i2c_mbe_pkg::CFG_CMD_PREFIX:  cfg.command_prefix     <= cfg_data[7:0];
        i2c_mbe_pkg::CFG_DATA_PREFIX: cfg.data_prefix        <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

endmodule

// ----- sv/i2c_mbe_core.sv -----
// Bit sequencer of the I2C master byte engine: state registers and the
// per-tick next-state logic. Depends on i2c_mbe_pkg.
module i2c_mbe_core (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 step,
  input  i2c_mbe_pkg::item_t   item,
  input  i2c_mbe_pkg::cfg_t    cfg,
  output i2c_mbe_pkg::res_t    res,
  output i2c_mbe_pkg::status_t status
);

  i2c_mbe_pkg::phase_t phase, phase_next, ent_ph;
  logic [3:0]  op_kind, op_kind_next;
  logic [15:0] slot_timer, slot_timer_next;
  logic [3:0]  bit_count, bit_count_next;
  logic [7:0]  shift_reg, shift_reg_next;
  logic [15:0] wait_count, wait_count_next;
  logic [1:0]  byte_index, byte_index_next;
  logic [7:0]  held_payload, held_payload_next;
  logic        scl_reg, scl_reg_next;
  logic        sda_reg, sda_reg_next;
  logic [7:0]  rx_reg, rx_reg_next;
  logic        nack_reg, nack_reg_next;
  logic        done_now;
  logic        ent;
  logic        is_trans;
  logic [15:0] slot_len;

  assign is_trans = (op_kind == i2c_mbe_pkg::REQ_CMD) || (op_kind == i2c_mbe_pkg::REQ_DATA);
  assign slot_len = (cfg.slot_ticks == 16'd0) ? 16'd1 : cfg.slot_ticks;

  always_comb begin
    phase_next        = phase;
    op_kind_next      = op_kind;
    slot_timer_next   = slot_timer;
    bit_count_next    = bit_count;
    shift_reg_next    = shift_reg;
    wait_count_next   = wait_count;
    byte_index_next   = byte_index;
    held_payload_next = held_payload;
    scl_reg_next      = scl_reg;
    sda_reg_next      = sda_reg;
    rx_reg_next       = rx_reg;
    nack_reg_next     = nack_reg;
    done_now          = 1'b0;
    ent               = 1'b0;
    ent_ph            = i2c_mbe_pkg::PH_IDLE;

    if (phase == i2c_mbe_pkg::PH_IDLE) begin
      if (item.req_type inside {[i2c_mbe_pkg::REQ_START:i2c_mbe_pkg::REQ_DATA]}) begin
        op_kind_next = item.req_type;
        ent = 1'b1;
        case (item.req_type)
          i2c_mbe_pkg::REQ_START: ent_ph = i2c_mbe_pkg::PH_ST_A;
          i2c_mbe_pkg::REQ_STOP:  ent_ph = i2c_mbe_pkg::PH_SP_A;
          i2c_mbe_pkg::REQ_WRITE: begin
            shift_reg_next = item.payload;
            bit_count_next = 4'd0;
            ent_ph = i2c_mbe_pkg::PH_WB_D;
          end
          i2c_mbe_pkg::REQ_READ: begin
            shift_reg_next = 8'd0;
            bit_count_next = 4'd0;
            ent_ph = i2c_mbe_pkg::PH_RB_H;
          end
          i2c_mbe_pkg::REQ_SACK: begin
            held_payload_next = {7'd0, item.ack_level};
            ent_ph = i2c_mbe_pkg::PH_SA_D;
          end
          i2c_mbe_pkg::REQ_RACK: ent_ph = i2c_mbe_pkg::PH_RA_D;
          default: begin
            held_payload_next = item.payload;
            byte_index_next = 2'd0;
            ent_ph = i2c_mbe_pkg::PH_ST_A;
          end
        endcase
      end
    end else if (phase == i2c_mbe_pkg::PH_RA_W || (phase == i2c_mbe_pkg::PH_RA_H &&
                 slot_timer <= 16'd1)) begin
      // ack wait: SCL stays high while SDA is released and time remains
      if (item.sda_in && wait_count != 16'd0) begin
        wait_count_next = wait_count - 16'd1;
        phase_next = i2c_mbe_pkg::PH_RA_W;
      end else begin
        nack_reg_next = item.sda_in;
        ent = 1'b1;
        ent_ph = i2c_mbe_pkg::PH_RA_L;
      end
    end else if (slot_timer > 16'd1) begin
      slot_timer_next = slot_timer - 16'd1;
    end else begin
      case (phase)
        i2c_mbe_pkg::PH_ST_A: begin
          ent = 1'b1;
          ent_ph = i2c_mbe_pkg::PH_ST_B;
        end
        i2c_mbe_pkg::PH_ST_B: begin
          scl_reg_next = 1'b0;
          if (is_trans) begin
            byte_index_next = 2'd0;
            shift_reg_next = cfg.slave_address_byte;
            bit_count_next = 4'd0;
            ent = 1'b1;
            ent_ph = i2c_mbe_pkg::PH_WB_D;
          end else begin
            phase_next = i2c_mbe_pkg::PH_IDLE;
            slot_timer_next = 16'd0;
            done_now = 1'b1;
          end
        end
        i2c_mbe_pkg::PH_SP_A: begin
          ent = 1'b1;
          ent_ph = i2c_mbe_pkg::PH_SP_B;
        end
        i2c_mbe_pkg::PH_WB_D: begin
          ent = 1'b1;
          ent_ph = i2c_mbe_pkg::PH_WB_H;
        end
        i2c_mbe_pkg::PH_WB_H: begin
          ent = 1'b1;
          ent_ph = i2c_mbe_pkg::PH_WB_L;
        end
        i2c_mbe_pkg::PH_WB_L: begin
          bit_count_next = bit_count + 4'd1;
          shift_reg_next = {shift_reg[6:0], 1'b0};
          if (bit_count_next < i2c_mbe_pkg::BITS_PER_BYTE) begin
            ent = 1'b1;
            ent_ph = i2c_mbe_pkg::PH_WB_D;
          end else if (is_trans) begin
            ent = 1'b1;
            ent_ph = i2c_mbe_pkg::PH_RA_D;
          end else begin
            phase_next = i2c_mbe_pkg::PH_IDLE;
            slot_timer_next = 16'd0;
            done_now = 1'b1;
          end
        end
        i2c_mbe_pkg::PH_RB_H: begin
          shift_reg_next = {shift_reg[6:0], item.sda_in};
          ent = 1'b1;
          ent_ph = i2c_mbe_pkg::PH_RB_L;
        end
        i2c_mbe_pkg::PH_RB_L: begin
          bit_count_next = bit_count + 4'd1;
          if (bit_count_next < i2c_mbe_pkg::BITS_PER_BYTE) begin
            ent = 1'b1;
            ent_ph = i2c_mbe_pkg::PH_RB_H;
          end else begin
            rx_reg_next = shift_reg;
            phase_next = i2c_mbe_pkg::PH_IDLE;
            slot_timer_next = 16'd0;
            done_now = 1'b1;
          end
        end
        i2c_mbe_pkg::PH_SA_D: begin
          ent = 1'b1;
          ent_ph = i2c_mbe_pkg::PH_SA_H;
        end
        i2c_mbe_pkg::PH_SA_H: begin
          ent = 1'b1;
          ent_ph = i2c_mbe_pkg::PH_SA_L;
        end
        i2c_mbe_pkg::PH_RA_D: begin
          ent = 1'b1;
          ent_ph = i2c_mbe_pkg::PH_RA_H;
        end
        i2c_mbe_pkg::PH_RA_L: begin
          if (!is_trans) begin
            phase_next = i2c_mbe_pkg::PH_IDLE;
            slot_timer_next = 16'd0;
            done_now = 1'b1;
          end else begin
            byte_index_next = byte_index + 2'd1;
            ent = 1'b1;
            if (byte_index_next == 2'd1) begin
              shift_reg_next = (op_kind == i2c_mbe_pkg::REQ_CMD) ? cfg.command_prefix :
                                                                   cfg.data_prefix;
              bit_count_next = 4'd0;
              ent_ph = i2c_mbe_pkg::PH_WB_D;
            end else if (byte_index_next == 2'd2) begin
              shift_reg_next = held_payload;
              bit_count_next = 4'd0;
              ent_ph = i2c_mbe_pkg::PH_WB_D;
            end else begin
              ent_ph = i2c_mbe_pkg::PH_SP_A;
            end
          end
        end
        default: begin
          phase_next = i2c_mbe_pkg::PH_IDLE;
          slot_timer_next = 16'd0;
          done_now = 1'b1;
        end
      endcase
    end

    // slot entry: load the timer and apply the pin action of the new slot
    if (ent) begin
      phase_next = ent_ph;
      slot_timer_next = slot_len;
      case (ent_ph)
        i2c_mbe_pkg::PH_ST_A: begin
          sda_reg_next = 1'b1;
          scl_reg_next = 1'b1;
        end
        i2c_mbe_pkg::PH_ST_B: sda_reg_next = 1'b0;
        i2c_mbe_pkg::PH_SP_A: begin
          sda_reg_next = 1'b0;
          scl_reg_next = 1'b1;
        end
        i2c_mbe_pkg::PH_SP_B: sda_reg_next = 1'b1;
        i2c_mbe_pkg::PH_WB_D: sda_reg_next = shift_reg_next[7];
        i2c_mbe_pkg::PH_SA_D: sda_reg_next = held_payload_next[0];
        i2c_mbe_pkg::PH_RA_D: sda_reg_next = 1'b1;
        i2c_mbe_pkg::PH_RB_H: begin
          sda_reg_next = 1'b1;
          scl_reg_next = 1'b1;
        end
        i2c_mbe_pkg::PH_RA_H: begin
          scl_reg_next = 1'b1;
          wait_count_next = cfg.ack_timeout;
        end
        i2c_mbe_pkg::PH_WB_H, i2c_mbe_pkg::PH_SA_H: scl_reg_next = 1'b1;
        default: scl_reg_next = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= i2c_mbe_pkg::PH_IDLE;
      op_kind      <= 4'd0;
      slot_timer   <= 16'd0;
      bit_count    <= 4'd0;
      shift_reg    <= 8'd0;
      wait_count   <= 16'd0;
      byte_index   <= 2'd0;
      held_payload <= 8'd0;
      scl_reg      <= 1'b1;
      sda_reg      <= 1'b1;
      rx_reg       <= 8'd0;
      nack_reg     <= 1'b0;
    end else if (step) begin
      phase        <= phase_next;
      op_kind      <= op_kind_next;
      slot_timer   <= slot_timer_next;
      bit_count    <= bit_count_next;
      shift_reg    <= shift_reg_next;
      wait_count   <= wait_count_next;
      byte_index   <= byte_index_next;
      held_payload <= held_payload_next;
      scl_reg      <= scl_reg_next;
      sda_reg      <= sda_reg_next;
      rx_reg       <= rx_reg_next;
      nack_reg     <= nack_reg_next;
    end
  end

  assign res.scl_level = scl_reg_next;
  assign res.sda_level = sda_reg_next;
  assign res.busy_res  = (phase_next != i2c_mbe_pkg::PH_IDLE);
  assign res.done_res  = done_now;
  assign res.rx_byte   = rx_reg_next;
  assign res.nack_seen = nack_reg_next;

  assign status.phase = phase;

endmodule

// ----- sv/i2c_master_byte_engine.sv -----
// Top level of the I2C master byte engine: input register, sequencer,
// result register and config port. Depends on i2c_mbe_pkg, i2c_mbe_cfg,
// i2c_mbe_core and i2c_master_byte_engine_macros.svh.
//
// Usage: every input transaction on the s_ stream is one tick. s_tuser
// carries the request code; a request is taken only while the sequencer
// is idle, otherwise the transaction acts as a plain tick. s_tdata also
// carries the sampled SDA level. Each tick produces exactly one result on
// the m_ stream with the driven SCL/SDA levels, busy, done, the last read
// byte and the last ack bit.
// Pipeline: a tick is held in the input register, its result then in the result
// register. Throughput: one tick per cycle unless m_tready holds the result
// register; the whole tick update is a single pass through the sequencer logic.
// Stall: when m_tready is low the result register holds, one more tick
// is parked in the input register, then s_tready drops.
// Reset: rst clears both stages, the sequencer goes idle with SCL and SDA
// released, config registers take their defaults. Config writes on the
// cfg_ channel are always accepted and belong between operations.
`include "i2c_master_byte_engine_macros.svh"
module i2c_master_byte_engine (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // payload[7:0], ack_level[8], sda_in[9], zero fill
  input  logic [3:0]  s_tuser,   // req_type[3:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // scl_level[0], sda_level[1], busy_res[2], done_res[3],
                                 // rx_byte[11:4], nack_seen[12], zero fill
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  i2c_mbe_pkg::cfg_t    cfg;
  i2c_mbe_pkg::item_t   in_item;
  i2c_mbe_pkg::res_t    core_res, out_res;
  i2c_mbe_pkg::status_t status;
  logic                 in_valid;
  logic                 out_valid;
  logic                 step;

  assign step     = in_valid && (!out_valid || m_tready);
  assign s_tready = !in_valid || step;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_valid <= 1'b1;
    end else if (step) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_item.req_type  <= s_tuser;
      in_item.payload   <= s_tdata[7:0];
      in_item.ack_level <= s_tdata[8];
      in_item.sda_in    <= s_tdata[9];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_res <= core_res;
    end
  end

  i2c_mbe_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  i2c_mbe_core u_core (
    .clk    (clk),
    .rst    (rst),
    .step   (step),
    .item   (in_item),
    .cfg    (cfg),
    .res    (core_res),
    .status (status)
  );

  assign m_tvalid = out_valid;
  assign m_tdata  = {3'd0, out_res.nack_seen, out_res.rx_byte, out_res.done_res,
                     out_res.busy_res, out_res.sda_level, out_res.scl_level};

  `MBE_CHECK_NEXT(a_hold_without_step, !step, $stable(status.phase),
                  "sequencer moved without a tick")
  `MBE_CHECK_NEXT(a_start_entry, step && status.phase == i2c_mbe_pkg::PH_IDLE &&
                  in_item.req_type == i2c_mbe_pkg::REQ_START,
                  status.phase == i2c_mbe_pkg::PH_ST_A, "start request not taken")
  `MBE_CHECK_NEXT(a_result_follows, step, out_valid, "tick produced no result")
  `MBE_CHECK_SAME(a_done_not_busy, out_valid && out_res.done_res, !out_res.busy_res,
                  "done reported while busy")

endmodule

// ----- sim/tb_i2c_master_byte_engine.sv -----
// Testbench for i2c_master_byte_engine: streams tick transactions through the
// block and checks every result against a tick-level model of the sequencer.
// Depends on i2c_mbe_pkg and the RTL of i2c_master_byte_engine.
module tb_i2c_master_byte_engine;
  import i2c_mbe_pkg::*;

  localparam int STALL_LIMIT = 2000;
  localparam int SDA_LOW = 0;
  localparam int SDA_HIGH = 1;
  localparam int SDA_RAND = 2;
  localparam logic [3:0] REQ_UNKNOWN_LO = 4'd9;
  localparam logic [3:0] REQ_UNKNOWN_HI = 4'hF;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [15:0] s_tdata = '0;
  logic [3:0]  s_tuser = REQ_TICK;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = CFG_SLOT_TICKS;
  logic [15:0] cfg_data = '0;

  i2c_master_byte_engine uut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  item_t tick_q[$];
  res_t  levels_due[$];
  item_t next_tick;
  res_t  want;
  int    errors = 0;
  int    results_seen = 0;
  int    send_gap = 0;
  int    hold_cnt = 0;
  int    quiet = 0;
  bit    held_once = 1'b0;
  bit    calm = 1'b0;

  // sequencer model state
  phase_t      ph;
  logic [3:0]  op;
  logic [15:0] slot_left, ack_wait;
  logic [3:0]  nbits;
  logic [7:0]  shreg, held, rx_q;
  logic [1:0]  byte_no;
  logic        scl_q, sda_q, nack_q, fin;
  cfg_t        regs;

  function automatic void seq_reset();
    regs.slot_ticks = SLOT_TICKS_RST;
    regs.ack_timeout = ACK_TIMEOUT_RST;
    regs.slave_address_byte = SLAVE_ADDR_RST;
    regs.command_prefix = CMD_PREFIX_RST;
    regs.data_prefix = DATA_PREFIX_RST;
    ph = PH_IDLE;
    op = REQ_TICK;
    slot_left = '0;
    ack_wait = '0;
    nbits = '0;
    shreg = '0;
    held = '0;
    rx_q = '0;
    byte_no = '0;
    scl_q = 1'b1;
    sda_q = 1'b1;
    nack_q = 1'b0;
    fin = 1'b0;
  endfunction

  function automatic void enter_slot(phase_t p);
    ph = p;
    slot_left = (regs.slot_ticks == 16'd0) ? 16'd1 : regs.slot_ticks;
    case (p)
      PH_ST_A: begin
        sda_q = 1'b1;
        scl_q = 1'b1;
      end
      PH_ST_B: sda_q = 1'b0;
      PH_SP_A: begin
        sda_q = 1'b0;
        scl_q = 1'b1;
      end
      PH_SP_B: sda_q = 1'b1;
      PH_WB_D: sda_q = shreg[7];
      PH_SA_D: sda_q = held[0];
      PH_RA_D: sda_q = 1'b1;
      PH_RB_H: begin
        sda_q = 1'b1;
        scl_q = 1'b1;
      end
      PH_RA_H: begin
        scl_q = 1'b1;
        ack_wait = regs.ack_timeout;
      end
      PH_WB_H, PH_SA_H: scl_q = 1'b1;
      default: scl_q = 1'b0;
    endcase
  endfunction

  function automatic void end_op();
    ph = PH_IDLE;
    slot_left = '0;
    fin = 1'b1;
  endfunction

  function automatic void load_byte(logic [7:0] b);
    shreg = b;
    nbits = '0;
    enter_slot(PH_WB_D);
  endfunction

  function automatic bit in_trans();
    return op == REQ_CMD || op == REQ_DATA;
  endfunction

  function automatic void sample_ack(logic sda);
    if (sda && ack_wait != 16'd0) begin
      ack_wait = ack_wait - 16'd1;
      ph = PH_RA_W;
    end else begin
      nack_q = sda;
      enter_slot(PH_RA_L);
    end
  endfunction

  function automatic void next_slot(logic sda);
    case (ph)
      PH_ST_A: enter_slot(PH_ST_B);
      PH_ST_B: begin
        scl_q = 1'b0;
        if (in_trans()) begin
          byte_no = '0;
          load_byte(regs.slave_address_byte);
        end else begin
          end_op();
        end
      end
      PH_SP_A: enter_slot(PH_SP_B);
      PH_WB_D: enter_slot(PH_WB_H);
      PH_WB_H: enter_slot(PH_WB_L);
      PH_WB_L: begin
        nbits = nbits + 4'd1;
        shreg = {shreg[6:0], 1'b0};
        if (nbits < BITS_PER_BYTE) enter_slot(PH_WB_D);
        else if (in_trans()) enter_slot(PH_RA_D);
        else end_op();
      end
      PH_RB_H: begin
        shreg = {shreg[6:0], sda};
        enter_slot(PH_RB_L);
      end
      PH_RB_L: begin
        nbits = nbits + 4'd1;
        if (nbits < BITS_PER_BYTE) begin
          enter_slot(PH_RB_H);
        end else begin
          rx_q = shreg;
          end_op();
        end
      end
      PH_SA_D: enter_slot(PH_SA_H);
      PH_SA_H: enter_slot(PH_SA_L);
      PH_RA_D: enter_slot(PH_RA_H);
      PH_RA_H: sample_ack(sda);
      PH_RA_L: begin
        if (!in_trans()) begin
          end_op();
        end else begin
          byte_no = byte_no + 2'd1;
          if (byte_no == 2'd1)
            load_byte(op == REQ_CMD ? regs.command_prefix : regs.data_prefix);
          else if (byte_no == 2'd2)
            load_byte(held);
          else
            enter_slot(PH_SP_A);
        end
      end
      default: end_op();
    endcase
  endfunction

  function automatic res_t sequencer_tick(logic [3:0] req, logic [7:0] pay, logic ack,
                                          logic sda);
    res_t r;
    fin = 1'b0;
    if (ph == PH_IDLE) begin
      if (req >= REQ_START && req <= REQ_DATA) begin
        op = req;
        case (req)
          REQ_START: enter_slot(PH_ST_A);
          REQ_STOP:  enter_slot(PH_SP_A);
          REQ_WRITE: load_byte(pay);
          REQ_READ: begin
            shreg = '0;
            nbits = '0;
            enter_slot(PH_RB_H);
          end
          REQ_SACK: begin
            held = {7'd0, ack};
            enter_slot(PH_SA_D);
          end
          REQ_RACK:  enter_slot(PH_RA_D);
          default: begin
            held = pay;
            byte_no = '0;
            enter_slot(PH_ST_A);
          end
        endcase
      end
    end else if (ph == PH_RA_W) begin
      sample_ack(sda);
    end else if (slot_left > 16'd1) begin
      slot_left = slot_left - 16'd1;
    end else begin
      next_slot(sda);
    end
    r.scl_level = scl_q;
    r.sda_level = sda_q;
    r.busy_res = (ph != PH_IDLE);
    r.done_res = fin;
    r.rx_byte = rx_q;
    r.nack_seen = nack_q;
    return r;
  endfunction

  function automatic void check_field(string name, logic [7:0] exp_v, logic [7:0] got_v);
    if (exp_v !== got_v) begin
      errors++;
      $error("%s: expected %0h, got %0h", name, exp_v, got_v);
    end
  endfunction

  // driver
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready)
        levels_due.push_back(sequencer_tick(s_tuser, s_tdata[7:0], s_tdata[8], s_tdata[9]));
      if (!s_tvalid || s_tready) begin
        if (send_gap != 0) begin
          send_gap--;
          s_tvalid <= 1'b0;
        end else if (tick_q.size() != 0 && !calm && $urandom_range(0, 15) == 0) begin
          send_gap = $urandom_range(0, 15);
          s_tvalid <= 1'b0;
        end else if (tick_q.size() != 0) begin
          next_tick = tick_q.pop_front();
          s_tvalid <= 1'b1;
          s_tuser <= next_tick.req_type;
          s_tdata <= {6'd0, next_tick.sda_in, next_tick.ack_level, next_tick.payload};
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // receiver backpressure, with one long hold to fill the pipeline
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_cnt != 0) begin
      hold_cnt--;
      m_tready <= 1'b0;
    end else if (!held_once && results_seen >= 600) begin
      held_once = 1'b1;
      hold_cnt = 119;
      m_tready <= 1'b0;
    end else if (!calm && $urandom_range(0, 15) == 0) begin
      hold_cnt = $urandom_range(0, 15);
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      results_seen++;
      if (levels_due.size() == 0) begin
        errors++;
        $error("unexpected result transaction: %h", m_tdata);
      end else begin
        want = levels_due.pop_front();
        check_field("scl_level", {7'd0, want.scl_level}, {7'd0, m_tdata[0]});
        check_field("sda_level", {7'd0, want.sda_level}, {7'd0, m_tdata[1]});
        check_field("busy_res", {7'd0, want.busy_res}, {7'd0, m_tdata[2]});
        check_field("done_res", {7'd0, want.done_res}, {7'd0, m_tdata[3]});
        check_field("rx_byte", want.rx_byte, m_tdata[11:4]);
        check_field("nack_seen", {7'd0, want.nack_seen}, {7'd0, m_tdata[12]});
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
      quiet <= 0;
    end else if (quiet == STALL_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_SLOT_TICKS:  regs.slot_ticks = val;
      CFG_ACK_TIMEOUT: regs.ack_timeout = val;
      CFG_SLAVE_ADDR:  regs.slave_address_byte = val[7:0];
      CFG_CMD_PREFIX:  regs.command_prefix = val[7:0];
      CFG_DATA_PREFIX: regs.data_prefix = val[7:0];
      default: ;
    endcase
  endtask

  task automatic apply_setting(input logic [15:0] slot, input logic [15:0] tmo,
                               input logic [7:0] addr, input logic [7:0] cmd,
                               input logic [7:0] dat);
    write_reg(CFG_SLOT_TICKS, slot);
    write_reg(CFG_ACK_TIMEOUT, tmo);
    write_reg(CFG_SLAVE_ADDR, {8'd0, addr});
    write_reg(CFG_CMD_PREFIX, {8'd0, cmd});
    write_reg(CFG_DATA_PREFIX, {8'd0, dat});
  endtask

  task automatic wait_drained();
    do @(negedge clk); while (tick_q.size() != 0 || s_tvalid || levels_due.size() != 0);
    repeat (4) @(negedge clk);
  endtask

  // one request followed by n plain ticks
  task automatic push_op(input logic [3:0] req, input logic [7:0] pay, input logic ack,
                         input int sda_mode, input int n);
    item_t it;
    it.req_type = req;
    it.payload = pay;
    it.ack_level = ack;
    it.sda_in = (sda_mode == SDA_RAND) ? 1'($urandom_range(0, 1)) : sda_mode[0];
    tick_q.push_back(it);
    repeat (n) begin
      it.req_type = REQ_TICK;
      it.payload = 8'($urandom_range(0, 255));
      it.ack_level = 1'($urandom_range(0, 1));
      it.sda_in = (sda_mode == SDA_RAND) ? 1'($urandom_range(0, 1)) : sda_mode[0];
      tick_q.push_back(it);
    end
  endtask

  task automatic push_random(input int count);
    int    pick;
    item_t it;
    repeat (count) begin
      pick = $urandom_range(0, 99);
      if (pick < 12) it.req_type = 4'($urandom_range(REQ_START, REQ_DATA));
      else if (pick < 15) it.req_type = 4'($urandom_range(REQ_UNKNOWN_LO, REQ_UNKNOWN_HI));
      else it.req_type = REQ_TICK;
      it.payload = 8'($urandom_range(0, 255));
      it.ack_level = 1'($urandom_range(0, 1));
      it.sda_in = 1'($urandom_range(0, 1));
      tick_q.push_back(it);
    end
  endtask

  task automatic run_random(input int count);
    push_random(count);
    push_op(REQ_TICK, 8'h00, 1'b0, SDA_LOW, 40);
    wait_drained();
  endtask

  initial begin
    seq_reset();
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    push_op(REQ_START, 8'h00, 1'b0, SDA_RAND, 4);
    push_op(REQ_WRITE, 8'hFF, 1'b0, SDA_RAND, 30);
    push_op(REQ_WRITE, 8'h00, 1'b1, SDA_RAND, 30);
    push_op(REQ_READ, 8'h00, 1'b0, SDA_HIGH, 30);
    push_op(REQ_READ, 8'hFF, 1'b0, SDA_LOW, 30);
    push_op(REQ_READ, 8'h00, 1'b0, SDA_RAND, 30);
    push_op(REQ_SACK, 8'hFF, 1'b0, SDA_RAND, 6);
    push_op(REQ_SACK, 8'h00, 1'b1, SDA_RAND, 6);
    push_op(REQ_RACK, 8'h00, 1'b0, SDA_LOW, 6);
    push_op(REQ_RACK, 8'h00, 1'b0, SDA_RAND, 10);
    push_op(REQ_STOP, 8'h00, 1'b0, SDA_RAND, 4);
    push_op(REQ_CMD, 8'hA5, 1'b0, SDA_LOW, 100);
    push_op(REQ_DATA, 8'h5A, 1'b1, SDA_RAND, 120);
    push_op(REQ_UNKNOWN_HI, 8'hFF, 1'b1, SDA_RAND, 2);
    push_op(REQ_UNKNOWN_LO, 8'h00, 1'b0, SDA_RAND, 2);
    // a write, then requests issued while it runs, which are dropped
    push_op(REQ_WRITE, 8'h3C, 1'b0, SDA_RAND, 2);
    push_op(REQ_START, 8'h00, 1'b0, SDA_RAND, 2);
    push_op(REQ_DATA, 8'hC3, 1'b0, SDA_RAND, 40);
    wait_drained();

    apply_setting(16'd1, 16'd3, 8'hFF, 8'h00, 8'hFF);
    run_random(140);
    apply_setting(16'd0, 16'd0, 8'h00, 8'hFF, 8'h00);
    run_random(140);
    apply_setting(16'd2, 16'hFFFF, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                  8'($urandom_range(0, 255)));
    run_random(140);
    apply_setting(16'($urandom_range(1, 3)), 16'($urandom_range(0, 20)),
                  8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                  8'($urandom_range(0, 255)));
    run_random(140);

    // long slot: a single start condition
    apply_setting(16'd40, 16'd0, 8'h00, 8'h00, 8'h00);
    push_op(REQ_START, 8'h00, 1'b0, SDA_LOW, 2 * 40 + 8);
    wait_drained();

    calm = 1'b1;
    apply_setting(SLOT_TICKS_RST, ACK_TIMEOUT_RST, SLAVE_ADDR_RST, CMD_PREFIX_RST,
                  DATA_PREFIX_RST);
    run_random(110);

    if (errors == 0 && levels_due.size() == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule

// ----- i2c_master_byte_engine.f -----
+incdir+sv
sv/i2c_mbe_pkg.sv
sv/i2c_mbe_cfg.sv
sv/i2c_mbe_core.sv
sv/i2c_master_byte_engine.sv
sim/tb_i2c_master_byte_engine.sv
